// File: design/assert_macros.svh
// Concurrent assertion helpers. Build with NO_ASSERTIONS defined to strip them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Check a condition at every clock edge outside reset.
`define ASSERT_HOLDS(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Check that an antecedent implies a consequent in the same cycle.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Check that an antecedent implies a consequent in the next cycle.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`else

`define ASSERT_HOLDS(label, clk, rst, expr, msg)
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

// File: design/bsq_pkg.sv
`default_nettype none

package bsq_pkg;

   localparam int DEPTH_DEFAULT = 8;
   localparam int WORD_W        = 32;
   localparam int FUNC_W        = 2;
   localparam int COUNT_OUT_W   = 4;

   typedef enum logic [FUNC_W-1:0] {
      FN_APPEND = 2'd0,
      FN_INSERT = 2'd1,
      FN_POP    = 2'd2,
      FN_SORT   = 2'd3
   } func_type;

   localparam logic [WORD_W-1:0] EMPTY_WORD = '1;

   // Result word, lowest field last.
   typedef struct packed {
      logic                   pad;
      logic                   dropped;
      logic                   is_full;
      logic [COUNT_OUT_W-1:0] item_count;
      logic [WORD_W-1:0]      head_value;
      logic                   popped_ok;
      logic [WORD_W-1:0]      popped_value;
   } rsp_word_type;

   localparam int RSP_DATA_W = $bits(rsp_word_type);

endpackage

`default_nettype wire

// File: design/bsq_ram.sv
`default_nettype none

module bsq_ram #(
   parameter int DEPTH = bsq_pkg::DEPTH_DEFAULT
) (
   input  wire logic                             clock,
   input  wire logic                             wr_en,
   input  wire logic [$clog2(DEPTH)-1:0]         wr_addr,
   input  wire logic [bsq_pkg::WORD_W-1:0]       wr_data,
   input  wire logic                             rd_en,
   input  wire logic [$clog2(DEPTH)-1:0]         rd_addr,
   output logic      [bsq_pkg::WORD_W-1:0]       rd_data
);

   logic [bsq_pkg::WORD_W-1:0] store_ff [DEPTH];
   logic [bsq_pkg::WORD_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= store_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: design/bounded_sorted_queue_unit.sv
`default_nettype none
`include "assert_macros.svh"

// Bounded sorted queue: a circular queue of DEPTH signed 32-bit words held in one
// single-port-write, registered-read memory. Each request word (req_tuser = operation,
// req_tdata = value) yields exactly one response word. Operations: append at the tail
// (dropped when full), sorted insert after all entries less than or equal to the
// value (when full the word at the tail, or the new one, is dropped), pop the head
// (-1 when empty) and a stable ascending sort. Every response carries the popped
// word, the new head (-1 when empty), the count, full and dropped flags.
// One request is worked at a time. A sorted insert into a non-empty queue, or a
// sort of two words or more, streams one memory read per cycle through the entries
// and rewrites them behind the reads, the rate set by the memory's single read
// port. A sort makes bubble passes over the memory, each one position shorter,
// stopping after the first pass with no swap or after the pass over two words. A
// new request is taken while the previous response still waits in the output
// register.
module bounded_sorted_queue_unit #(
   parameter int DEPTH = bsq_pkg::DEPTH_DEFAULT
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   // request
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   input  wire logic [bsq_pkg::WORD_W-1:0]       req_tdata,  // [31:0] value
   input  wire logic [bsq_pkg::FUNC_W-1:0]       req_tuser,  // [1:0] func
   // response
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   // [31:0] popped_value, [32] popped_ok, [64:33] head_value,
   // [68:65] item_count, [69] is_full, [70] dropped, [71] zero
   output logic      [bsq_pkg::RSP_DATA_W-1:0]   rsp_tdata
);

   localparam int PW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_POP    = 6'b000010,
      ST_SCAN   = 6'b000100,
      ST_FINISH = 6'b001000,
      ST_HEAD   = 6'b010000,
      ST_DONE   = 6'b100000
   } state_type;

   state_type                      state_ff, state_in;
   bsq_pkg::func_type              func_ff, func_in;
   logic [bsq_pkg::WORD_W-1:0]     value_ff, value_in;
   logic [PW-1:0]                  head_ff, head_in;
   logic [CW-1:0]                  occ_ff, occ_in;
   logic [PW-1:0]                  last_ff, last_in;
   logic [PW-1:0]                  iss_ff, iss_in;
   logic                           iss_on_ff, iss_on_in;
   logic                           dv_ff, dv_in;
   logic [PW-1:0]                  dpos_ff, dpos_in;
   logic [bsq_pkg::WORD_W-1:0]     carry_ff, carry_in;
   logic                           placed_ff, placed_in;
   logic                           swapped_ff, swapped_in;
   logic [bsq_pkg::WORD_W-1:0]     popped_ff, popped_in;
   logic                           ok_ff, ok_in;
   logic                           drop_ff, drop_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   bsq_pkg::rsp_word_type          rsp_data_ff, rsp_data_in;

   logic                           wr_en;
   logic [PW-1:0]                  wr_addr;
   logic [bsq_pkg::WORD_W-1:0]     wr_data;
   logic                           rd_en;
   logic [PW-1:0]                  rd_addr;
   logic [bsq_pkg::WORD_W-1:0]     rd_data;
   logic                           req_accept;
   logic                           is_full;
   logic                           full_append;

   // Map a logical position (0 = head) to a memory address.
   function automatic logic [PW-1:0] slot(input logic [PW-1:0] pos);
      logic [PW:0] sum;
      sum = {1'b0, head_ff} + {1'b0, pos};
      if (sum >= (PW+1)'(DEPTH)) begin
         sum = sum - (PW+1)'(DEPTH);
      end
      return sum[PW-1:0];
   endfunction

   bsq_ram #(
      .DEPTH(DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign req_tready = (state_ff == ST_IDLE) && !reset;
   assign req_accept = req_tvalid && req_tready;
   assign is_full    = (occ_ff == CW'(DEPTH));

   always_comb begin
      state_in     = state_ff;
      func_in      = func_ff;
      value_in     = value_ff;
      head_in      = head_ff;
      occ_in       = occ_ff;
      last_in      = last_ff;
      iss_in       = iss_ff;
      iss_on_in    = iss_on_ff;
      dv_in        = 1'b0;
      dpos_in      = dpos_ff;
      carry_in     = carry_ff;
      placed_in    = placed_ff;
      swapped_in   = swapped_ff;
      popped_in    = popped_ff;
      ok_in        = ok_ff;
      drop_in      = drop_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      wr_en        = 1'b0;
      wr_addr      = head_ff;
      wr_data      = value_ff;
      rd_en        = 1'b0;
      rd_addr      = head_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               // latch the request and clear per-request flags
               func_in    = bsq_pkg::func_type'(req_tuser);
               value_in   = req_tdata;
               popped_in  = bsq_pkg::EMPTY_WORD;
               ok_in      = 1'b0;
               drop_in    = 1'b0;
               placed_in  = 1'b0;
               swapped_in = 1'b0;
               iss_in     = '0;
               iss_on_in  = 1'b1;
               last_in    = PW'(occ_ff - CW'(1));
               state_in   = ST_HEAD;
               unique case (bsq_pkg::func_type'(req_tuser))
                  bsq_pkg::FN_APPEND: begin
                     if (is_full) begin
                        drop_in = 1'b1;
                     end else begin
                        wr_en   = 1'b1;
                        wr_addr = slot(PW'(occ_ff));
                        wr_data = req_tdata;
                        occ_in  = occ_ff + CW'(1);
                     end
                  end
                  bsq_pkg::FN_INSERT: begin
                     state_in = (occ_ff == '0) ? ST_FINISH : ST_SCAN;
                  end
                  bsq_pkg::FN_POP: begin
                     if (occ_ff != '0) begin
                        rd_en    = 1'b1;
                        rd_addr  = head_ff;
                        state_in = ST_POP;
                     end
                  end
                  default: begin
                     if (occ_ff >= CW'(2)) begin
                        state_in = ST_SCAN;
                     end
                  end
               endcase
            end
         end

         ST_POP: begin
            popped_in = rd_data;
            ok_in     = 1'b1;
            occ_in    = occ_ff - CW'(1);
            head_in   = (occ_ff == CW'(1)) ? '0 : slot(PW'(1));
            state_in  = ST_HEAD;
         end

         ST_SCAN: begin
            // issue side: stream reads of positions 0..last
            if (iss_on_ff) begin
               rd_en   = 1'b1;
               rd_addr = slot(iss_ff);
               dv_in   = 1'b1;
               dpos_in = iss_ff;
               iss_in  = iss_ff + PW'(1);
               if (iss_ff == last_ff) begin
                  iss_on_in = 1'b0;
               end
            end
            // data side: one word back from the memory, rewrite behind the reads
            if (dv_ff) begin
               if (func_ff == bsq_pkg::FN_INSERT) begin
                  if (!placed_ff && ($signed(rd_data) > $signed(value_ff))) begin
                     wr_en     = 1'b1;
                     wr_addr   = slot(dpos_ff);
                     wr_data   = value_ff;
                     carry_in  = rd_data;
                     placed_in = 1'b1;
                  end else if (placed_ff) begin
                     wr_en    = 1'b1;
                     wr_addr  = slot(dpos_ff);
                     wr_data  = carry_ff;
                     carry_in = rd_data;
                  end
               end else begin
                  // bubble pass: carry the larger word forward
                  if (dpos_ff == '0) begin
                     carry_in = rd_data;
                  end else if ($signed(carry_ff) > $signed(rd_data)) begin
                     wr_en      = 1'b1;
                     wr_addr    = slot(dpos_ff - PW'(1));
                     wr_data    = rd_data;
                     swapped_in = 1'b1;
                  end else begin
                     wr_en    = 1'b1;
                     wr_addr  = slot(dpos_ff - PW'(1));
                     wr_data  = carry_ff;
                     carry_in = rd_data;
                  end
               end
               if (dpos_ff == last_ff) begin
                  state_in = ST_FINISH;
               end
            end
         end

         ST_FINISH: begin
            state_in = ST_HEAD;
            if (func_ff == bsq_pkg::FN_INSERT) begin
               // place the trailing word, or drop it when full
               if (is_full) begin
                  drop_in = 1'b1;
               end else begin
                  wr_en   = 1'b1;
                  wr_addr = slot(PW'(occ_ff));
                  wr_data = placed_ff ? carry_ff : value_ff;
                  occ_in  = occ_ff + CW'(1);
               end
            end else begin
               wr_en   = 1'b1;
               wr_addr = slot(last_ff);
               wr_data = carry_ff;
               if (swapped_ff && (last_ff > PW'(1))) begin
                  // another pass, one position shorter
                  last_in    = last_ff - PW'(1);
                  iss_in     = '0;
                  iss_on_in  = 1'b1;
                  swapped_in = 1'b0;
                  state_in   = ST_SCAN;
               end
            end
         end

         ST_HEAD: begin
            rd_en    = 1'b1;
            rd_addr  = head_ff;
            state_in = ST_DONE;
         end

         ST_DONE: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in             = 1'b1;
               rsp_data_in.pad          = 1'b0;
               rsp_data_in.dropped      = drop_ff;
               rsp_data_in.is_full      = is_full;
               rsp_data_in.item_count   = bsq_pkg::COUNT_OUT_W'(occ_ff);
               rsp_data_in.head_value   = (occ_ff == '0) ? bsq_pkg::EMPTY_WORD : rd_data;
               rsp_data_in.popped_ok    = ok_ff;
               rsp_data_in.popped_value = popped_ff;
               state_in                 = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         occ_ff       <= '0;
         iss_on_ff    <= 1'b0;
         dv_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         occ_ff       <= occ_in;
         iss_on_ff    <= iss_on_in;
         dv_ff        <= dv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff     <= func_in;
      value_ff    <= value_in;
      last_ff     <= last_in;
      iss_ff      <= iss_in;
      dpos_ff     <= dpos_in;
      carry_ff    <= carry_in;
      placed_ff   <= placed_in;
      swapped_ff  <= swapped_in;
      popped_ff   <= popped_in;
      ok_ff       <= ok_in;
      drop_ff     <= drop_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign full_append = req_accept && is_full && (req_tuser == bsq_pkg::FN_APPEND);

   // Occupancy never exceeds the depth.
   `ASSERT_HOLDS(a_occ_bound, clock, reset, occ_ff <= CW'(DEPTH), "occupancy above depth")
   // An empty queue keeps its head at address zero.
   `ASSERT_IMPLIES(a_empty_head, clock, reset, occ_ff == '0, head_ff == '0, "empty head moved")
   // A scan only runs over a non-empty queue.
   `ASSERT_IMPLIES(a_scan_nonempty, clock, reset, state_ff == ST_SCAN, occ_ff != '0, "scan empty")
   // An append to a full queue leaves the count alone.
   `ASSERT_NEXT(a_full_append, clock, reset, full_append, $stable(occ_ff), "full append moved")

endmodule

`default_nettype wire

// File: tb/sv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
   import bsq_pkg::*;

   localparam int QUEUE_DEPTH  = DEPTH_DEFAULT;
   localparam int RANDOM_WORDS = 1025;
   // one long receiver hold-off, started once this many request words went in
   localparam int HOLD_AFTER   = 400;
   localparam int HOLD_CYCLES  = 300;
   // quiet cycles after the last response, to catch stray words
   localparam int DRAIN_CYCLES = 100;
   // worst case: ~1050 sorts of a full queue, slow receiver, gaps,
   // one long hold-off; taken several times over
   localparam int CYCLE_LIMIT  = 400000;

   // one row of the directed sequence; want is used only when typed is set
   typedef struct packed {
      func_type          fn;
      logic [WORD_W-1:0] value;
      logic              typed;
      rsp_word_type      want;
   } stimulus_row_type;

   logic                  clock;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [WORD_W-1:0]     req_tdata  = '0;        // [31:0] value
   logic [FUNC_W-1:0]     req_tuser  = FN_APPEND; // [1:0] func
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   // [31:0] popped_value, [32] popped_ok, [64:33] head_value,
   // [68:65] item_count, [69] is_full, [70] dropped, [71] zero
   logic [RSP_DATA_W-1:0] rsp_tdata;

   // Shadow copy of the queue, held in logical order with the head at index 0.
   // The extra slot takes the word that a sorted insert into a full queue pushes out.
   logic signed [WORD_W-1:0] shadow_words [0:QUEUE_DEPTH];
   int                       shadow_count = 0;

   rsp_word_type     pending_results [$];
   stimulus_row_type directed_rows [$];

   int mismatch_count = 0;
   int accepted_words = 0;
   int checked_words  = 0;
   int burst_left     = 0;
   int op_count [0:3] = '{0, 0, 0, 0};
   int empty_pops     = 0;
   int drop_count     = 0;
   int full_count     = 0;

   bounded_sorted_queue_unit #(
      .DEPTH(QUEUE_DEPTH)
   ) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Apply one operation to the shadow queue and return the response word it
   // should produce.
   function automatic rsp_word_type apply_queue_op(input func_type fn,
                                                   input logic signed [WORD_W-1:0] value);
      rsp_word_type             r;
      int                       pos;
      int                       k;
      logic signed [WORD_W-1:0] carry;
      r = '0;
      r.popped_value = EMPTY_WORD;
      op_count[fn]++;
      case (fn)
         FN_APPEND: begin
            if (shadow_count >= QUEUE_DEPTH) begin
               r.dropped = 1'b1;
            end else begin
               shadow_words[shadow_count] = value;
               shadow_count++;
            end
         end
         FN_INSERT: begin
            // land after every entry less than or equal to the new word
            pos = shadow_count;
            for (k = shadow_count - 1; k >= 0; k--) begin
               if (shadow_words[k] > value) pos = k;
            end
            for (k = shadow_count; k > pos; k--) shadow_words[k] = shadow_words[k-1];
            shadow_words[pos] = value;
            // a full queue keeps its first DEPTH words: the last one falls off
            if (shadow_count == QUEUE_DEPTH) r.dropped = 1'b1;
            else shadow_count++;
         end
         FN_POP: begin
            if (shadow_count > 0) begin
               r.popped_value = shadow_words[0];
               r.popped_ok    = 1'b1;
               for (k = 0; k < shadow_count - 1; k++) shadow_words[k] = shadow_words[k+1];
               shadow_count--;
            end else begin
               empty_pops++;
            end
         end
         default: begin
            // stable ascending sort: move a word left only past strictly larger ones
            for (k = 1; k < shadow_count; k++) begin
               carry = shadow_words[k];
               pos   = k;
               while (pos > 0 && shadow_words[pos-1] > carry) begin
                  shadow_words[pos] = shadow_words[pos-1];
                  pos--;
               end
               shadow_words[pos] = carry;
            end
         end
      endcase
      r.head_value = (shadow_count > 0) ? shadow_words[0] : EMPTY_WORD;
      r.item_count = shadow_count[COUNT_OUT_W-1:0];
      r.is_full    = (shadow_count == QUEUE_DEPTH);
      if (r.dropped) drop_count++;
      if (r.is_full) full_count++;
      return r;
   endfunction

   function automatic rsp_word_type make_result(input logic [WORD_W-1:0] popped,
                                                input logic ok,
                                                input logic [WORD_W-1:0] head,
                                                input int count,
                                                input logic full,
                                                input logic lost);
      rsp_word_type r;
      r = '0;
      r.popped_value = popped;
      r.popped_ok    = ok;
      r.head_value   = head;
      r.item_count   = count[COUNT_OUT_W-1:0];
      r.is_full      = full;
      r.dropped      = lost;
      return r;
   endfunction

   function automatic void add_row(input func_type fn, input logic [WORD_W-1:0] value,
                                   input logic typed, input rsp_word_type want);
      stimulus_row_type row;
      row.fn    = fn;
      row.value = value;
      row.typed = typed;
      row.want  = want;
      directed_rows.push_back(row);
   endfunction

   // Sender pacing: bursts of random length, random gaps between them.
   // Drop valid only when a gap really follows, so it never toggles within a step.
   task automatic pace_sender();
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 20);
      end
      burst_left--;
   endtask

   // Offer one request word and hold it until the block takes it. Record the
   // expected response at the accepting edge.
   task automatic send_word(input func_type fn, input logic [WORD_W-1:0] value,
                            input logic typed, input rsp_word_type want);
      rsp_word_type model_result;
      req_tvalid <= 1'b1;
      req_tuser  <= fn;
      req_tdata  <= value;
      do @(posedge clock); while (!req_tready);
      model_result = apply_queue_op(fn, value);
      pending_results.push_back(typed ? want : model_result);
      accepted_words++;
   endtask

   task automatic check_field(input string name, input logic [WORD_W-1:0] want,
                              input logic [WORD_W-1:0] got);
      if (want !== got) begin
         $display("%0t: response %0d, %s mismatch: expected %h, actual %h",
                  $time, checked_words, name, want, got);
         mismatch_count++;
      end
   endtask

   // Response checker: compare every accepted response word with the oldest
   // expectation, field by field.
   always @(posedge clock) begin : response_check
      rsp_word_type want;
      rsp_word_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         if (pending_results.size() == 0) begin
            $display("%0t: response word with nothing expected: expected none, actual %h",
                     $time, got);
            mismatch_count++;
         end else begin
            want = pending_results.pop_front();
            check_field("popped_value", want.popped_value, got.popped_value);
            check_field("popped_ok",    WORD_W'(want.popped_ok),  WORD_W'(got.popped_ok));
            check_field("head_value",   want.head_value,   got.head_value);
            check_field("item_count",   WORD_W'(want.item_count), WORD_W'(got.item_count));
            check_field("is_full",      WORD_W'(want.is_full),    WORD_W'(got.is_full));
            check_field("dropped",      WORD_W'(want.dropped),    WORD_W'(got.dropped));
            check_field("pad",          WORD_W'(want.pad),        WORD_W'(got.pad));
         end
         checked_words++;
      end
   end

   // Receiver pacing: segments of always-ready, coin-flip and mostly-stalled
   // behavior, plus one long hold-off so the block backs up and stalls its input.
   initial begin : response_pacing
      int  seg_mode;
      int  seg_left;
      int  hold_count;
      bit  hold_done;
      seg_mode  = 0;
      seg_left  = 0;
      hold_done = 1'b0;
      forever begin
         @(posedge clock);
         if (!hold_done && accepted_words >= HOLD_AFTER) begin
            rsp_tready <= 1'b0;
            hold_count = 0;
            while (hold_count < HOLD_CYCLES) begin
               @(posedge clock);
               hold_count++;
            end
            hold_done = 1'b1;
         end else begin
            if (seg_left == 0) begin
               seg_mode = $urandom_range(0, 2);
               seg_left = $urandom_range(8, 64);
            end
            seg_left--;
            case (seg_mode)
               0:       rsp_tready <= 1'b1;
               1:       rsp_tready <= 1'($urandom_range(0, 1));
               default: rsp_tready <= ($urandom_range(0, 3) == 0);
            endcase
         end
      end
   end

   // Watchdog: end the run if the cycle count runs past the limit.
   initial begin : watchdog
      int cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("%0t: timeout after %0d cycles, %0d responses still expected",
               $time, cycles, pending_results.size());
      $display("Verification failed");
      $finish;
   end

   initial begin : stimulus
      rsp_word_type      none;
      stimulus_row_type  row;
      func_type          fn;
      logic [WORD_W-1:0] value;
      int                k;
      int                roll;
      int                traffic_mode;
      int                append_lim;
      int                insert_lim;
      int                pop_lim;
      none = '0;

      // Directed part. Rows with an obvious answer carry it; the rest go
      // through the shadow model.
      // pop and sort on the empty queue right after reset
      add_row(FN_POP,  32'h0000_0000, 1'b1,
              make_result(EMPTY_WORD, 1'b0, EMPTY_WORD, 0, 1'b0, 1'b0));
      add_row(FN_SORT, 32'hFFFF_FFFF, 1'b1,
              make_result(EMPTY_WORD, 1'b0, EMPTY_WORD, 0, 1'b0, 1'b0));
      // extremes, out of order, then sorted
      add_row(FN_APPEND, 32'h7FFF_FFFF, 1'b1,
              make_result(EMPTY_WORD, 1'b0, 32'h7FFF_FFFF, 1, 1'b0, 1'b0));
      add_row(FN_APPEND, 32'h8000_0000, 1'b1,
              make_result(EMPTY_WORD, 1'b0, 32'h7FFF_FFFF, 2, 1'b0, 1'b0));
      add_row(FN_SORT, 32'h0000_0000, 1'b1,
              make_result(EMPTY_WORD, 1'b0, 32'h8000_0000, 2, 1'b0, 1'b0));
      // sorted inserts, one of them equal to an entry already held
      add_row(FN_INSERT, 32'hFFFF_FFFF, 1'b0, none);
      add_row(FN_INSERT, 32'h0000_0000, 1'b0, none);
      add_row(FN_INSERT, 32'h0000_0000, 1'b0, none);
      // fill to the top with plain appends
      add_row(FN_APPEND, 32'h0000_0005, 1'b0, none);
      add_row(FN_APPEND, 32'h0000_0003, 1'b0, none);
      add_row(FN_APPEND, 32'hFFFF_FFFF, 1'b0, none);
      // append on a full queue is dropped and nothing moves
      add_row(FN_APPEND, 32'h0000_0001, 1'b1,
              make_result(EMPTY_WORD, 1'b0, 32'h8000_0000, QUEUE_DEPTH, 1'b1, 1'b1));
      // insert on a full queue: new word dropped, then the tail word dropped
      add_row(FN_INSERT, 32'h7FFF_FFFF, 1'b0, none);
      add_row(FN_INSERT, 32'h8000_0000, 1'b0, none);
      add_row(FN_SORT,   32'h1234_5678, 1'b0, none);
      // drain completely; the last pop brings the head back to empty
      for (k = 0; k < QUEUE_DEPTH; k++) add_row(FN_POP, 32'hA5A5_A5A5, 1'b0, none);
      add_row(FN_POP, 32'h0000_0000, 1'b1,
              make_result(EMPTY_WORD, 1'b0, EMPTY_WORD, 0, 1'b0, 1'b0));
      add_row(FN_INSERT, 32'h1234_5678, 1'b1,
              make_result(EMPTY_WORD, 1'b0, 32'h1234_5678, 1, 1'b0, 1'b0));

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         pace_sender();
         send_word(row.fn, row.value, row.typed, row.want);
      end

      // Random part: traffic leans toward filling, draining or an even mix, so
      // the queue keeps swinging between empty and full.
      traffic_mode = 0;
      for (k = 0; k < RANDOM_WORDS; k++) begin
         if (k % 24 == 0) traffic_mode = $urandom_range(0, 2);
         case (traffic_mode)
            0:       begin append_lim = 35; insert_lim = 80; pop_lim = 90; end
            1:       begin append_lim = 15; insert_lim = 30; pop_lim = 85; end
            default: begin append_lim = 25; insert_lim = 50; pop_lim = 75; end
         endcase
         roll = $urandom_range(0, 99);
         if (roll < append_lim)      fn = FN_APPEND;
         else if (roll < insert_lim) fn = FN_INSERT;
         else if (roll < pop_lim)    fn = FN_POP;
         else                        fn = FN_SORT;
         // small values give frequent ties; extremes and full-width words too
         case ($urandom_range(0, 9))
            0, 1, 2, 3: value = $urandom_range(0, 8) - 4;
            4: begin
               case ($urandom_range(0, 4))
                  0:       value = 32'h8000_0000;
                  1:       value = 32'h7FFF_FFFF;
                  2:       value = EMPTY_WORD;
                  3:       value = 32'h0000_0000;
                  default: value = 32'h0000_0001;
               endcase
            end
            default: value = $urandom();
         endcase
         pace_sender();
         send_word(fn, value, 1'b0, none);
      end
      req_tvalid <= 1'b0;

      // wait for every expected response, then watch for stray words
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Run covered %0d words: %0d appends, %0d inserts, %0d pops (%0d empty), %0d sorts.",
               accepted_words, op_count[FN_APPEND], op_count[FN_INSERT],
               op_count[FN_POP], empty_pops, op_count[FN_SORT]);
      $display("%0d words dropped when full, %0d ops left it full, %0d responses checked.",
               drop_count, full_count, checked_words);
      if (mismatch_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
